// ===== rtl/ads_pkg.sv =====
// Shared types and constants of the area-average line downscaler.
package ads_pkg;

  localparam int PIX_W      = 8;
  localparam int WGT_W      = 12;
  localparam int WIDTH_W    = 13;
  localparam int CNT_W      = 12;
  localparam int SUM_W      = 20;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PER_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_PER_OUTPUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH      = 2'd2;

  localparam logic [PIX_W-1:0]  PIX_MAX   = 8'hFF;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  typedef struct packed {
    logic [WGT_W-1:0]   weight_per_source;
    logic [WGT_W-1:0]   weight_per_output;
    logic [WIDTH_W-1:0] output_width;
  } ads_cfg_t;

  // One finished output waiting for its division.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [WGT_W-1:0] den;
    logic             last;
  } ads_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } ads_back_state_t;

endpackage

// ===== rtl/ads_front.sv =====
// Front end: takes source pixels, gathers weight units and emits finished sums.
module ads_front
  import ads_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ads_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_source_pixel,
  input  logic             q_full,
  output logic             push,
  output ads_job_t         push_job
);

  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (MW_W > WIDTH_W) ? MW_W : WIDTH_W;

  logic [SUM_W-1:0] ws_r, ws_nxt;
  logic [WGT_W-1:0] ug_r, ug_nxt;
  logic [CNT_W-1:0] od_r, od_nxt;

  logic             accept;
  logic [WGT_W-1:0] den, num_nz, num, room;
  logic [SUM_W-1:0] prod_num, prod_part, prod_rest;
  logic [CMP_W-1:0] width_nz, width_eff, done_cnt;
  logic             fills, last;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    den    = (cfg.weight_per_output == '0) ? WGT_W'(1) : cfg.weight_per_output;
    num_nz = (cfg.weight_per_source == '0) ? WGT_W'(1) : cfg.weight_per_source;
    num    = (num_nz > den) ? den : num_nz;
    room   = (ug_r < den) ? (den - ug_r) : '0;
    fills  = !(num < room);

    prod_num  = SUM_W'(in_source_pixel) * SUM_W'(num);
    prod_part = SUM_W'(in_source_pixel) * SUM_W'(room);
    // pix * (num - room), exact since num is at least room when it is used.
    prod_rest = prod_num - prod_part;

    width_nz  = (cfg.output_width == '0) ? CMP_W'(1) : CMP_W'(cfg.output_width);
    width_eff = (width_nz > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_nz;
    done_cnt  = CMP_W'(od_r) + CMP_W'(1);
    last      = (done_cnt >= width_eff);

    push          = accept && fills;
    push_job.sum  = ws_r + prod_part;
    push_job.den  = den;
    push_job.last = last;

    ws_nxt = ws_r;
    ug_nxt = ug_r;
    od_nxt = od_r;
    if (accept) begin
      if (!fills) begin
        ws_nxt = ws_r + prod_num;
        ug_nxt = ug_r + num;
      end else if (last) begin
        ws_nxt = '0;
        ug_nxt = '0;
        od_nxt = '0;
      end else begin
        ws_nxt = prod_rest;
        ug_nxt = num - room;
        od_nxt = od_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= '0;
      ug_r <= '0;
      od_r <= '0;
    end else begin
      ws_r <= ws_nxt;
      ug_r <= ug_nxt;
      od_r <= od_nxt;
    end
  end

endmodule

// ===== rtl/ads_queue.sv =====
// Short job queue between the front end and the divider.
module ads_queue
  import ads_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ads_job_t push_job,
  input  logic     pop,
  output ads_job_t head_job,
  output logic     empty,
  output logic     full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ads_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/ads_back.sv =====
// Back end: restoring divider with round-half-even, saturation and output register.
module ads_back
  import ads_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ads_job_t         head_job,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_output_pixel,
  output logic             out_last_of_line
);

  ads_back_state_t state_r, state_nxt;

  logic [SUM_W-1:0]  dq_r;
  logic [WGT_W-1:0]  rem_r, den_r;
  logic              last_r;
  logic [STEP_W-1:0] step_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  logic             out_free, out_load, div_step;
  logic [WGT_W:0]   rem_sh, rem_sub, twice_rem;
  logic             ge, inc;
  logic [SUM_W:0]   q_rnd;
  logic [PIX_W-1:0] pix_fin;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (step_r == STEP_LAST) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE: pop      = !q_empty;
      BK_DIV:  div_step = 1'b1;
      BK_FIN:  out_load = out_free;
      default: pop      = 1'b0;
    endcase
  end

  always_comb begin
    rem_sh    = {rem_r, dq_r[SUM_W-1]};
    rem_sub   = rem_sh - {1'b0, den_r};
    ge        = (rem_sh >= {1'b0, den_r});
    twice_rem = {rem_r, 1'b0};
    inc       = (twice_rem > {1'b0, den_r}) || ((twice_rem == {1'b0, den_r}) && dq_r[0]);
    q_rnd     = {1'b0, dq_r} + (SUM_W + 1)'(inc);
    pix_fin   = (q_rnd > (SUM_W + 1)'(PIX_MAX)) ? PIX_MAX : q_rnd[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dq_r   <= head_job.sum;
      den_r  <= head_job.den;
      last_r <= head_job.last;
      rem_r  <= '0;
      step_r <= '0;
    end else if (div_step) begin
      rem_r  <= ge ? rem_sub[WGT_W-1:0] : rem_sh[WGT_W-1:0];
      dq_r   <= {dq_r[SUM_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (out_load) begin
      out_pixel_r <= pix_fin;
      out_last_r  <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_output_pixel = out_pixel_r;
  assign out_last_of_line = out_last_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FIN) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (den_r != '0))
    else $error("division by zero in progress");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == BK_FIN))
    else $error("result raised outside the finish step");

endmodule

// ===== rtl/area_downscale_line.sv =====
// Top level of the horizontal area-average line downscaler.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_source_pixel[7:0]
//   out      output     out_valid/out_stall out_output_pixel[7:0], out_last_of_line
//   cfg      input      cfg_we              cfg_index[1:0], cfg_data[12:0]
//
// A source pixel is taken every cycle while the job queue has room. For each
// output pixel the divider loads the job, runs 20 restoring steps, then rounds
// and registers the result, so that unit sets the sustained output rate. Reset
// is synchronous and active low; it clears the running sum, counters and queue
// and sets all three registers to 1. in_stall rises while the queue holds
// QUEUE_DEPTH jobs; out_stall holds the output register, and the divider waits
// in its finish step until it is free.
module area_downscale_line
  import ads_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_source_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_output_pixel,
  output logic                  out_last_of_line
);

  // Configuration registers. A write never touches the running state, so a
  // change in the middle of a line takes effect with the next source pixel.
  ads_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WEIGHT_PER_SOURCE: cfg_nxt.weight_per_source = cfg_data[WGT_W-1:0];
        CFG_WEIGHT_PER_OUTPUT: cfg_nxt.weight_per_output = cfg_data[WGT_W-1:0];
        CFG_OUTPUT_WIDTH:      cfg_nxt.output_width      = cfg_data[WIDTH_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weight_per_source <= WGT_W'(1);
      cfg_r.weight_per_output <= WGT_W'(1);
      cfg_r.output_width      <= WIDTH_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end finishes an output's weighted sum in the cycle its last
  // units arrive and hands the sum, divisor and end-of-line flag to the queue.
  logic     push, pop, q_empty, q_full;
  ads_job_t push_job, head_job;

  ads_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_source_pixel (in_source_pixel),
    .q_full          (q_full),
    .push            (push),
    .push_job        (push_job)
  );

  ads_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end divides one job at a time, rounds half to even, saturates
  // at full scale and presents the result on the output channel.
  ads_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_job         (head_job),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_output_pixel (out_output_pixel),
    .out_last_of_line (out_last_of_line)
  );

endmodule
